FILE: hw/rtl/vpts_pkg.sv
// Package for the vertex perspective-to-screen block.
// Holds the transaction payload types and configuration register codes.
// No dependencies.
package vpts_pkg;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_DEPTH_A  = 3'd2,
    REG_DEPTH_B  = 3'd3,
    REG_SCREEN_W = 3'd4,
    REG_SCREEN_H = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] z_pos;
    logic signed [15:0] w_pos;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [23:0] ndc_depth;
    logic               w_was_zero;
  } scr_t;

  typedef struct packed {
    reg_idx_e    idx;
    logic [23:0] wdata;
  } cfg_t;

  localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q_MIN = -24'sh800000;
  localparam int unsigned        UNIT_DIV = 100000;

endpackage

FILE: hw/rtl/vpts_if.sv
// Valid/ready channel interfaces of the vertex perspective-to-screen block.
// Depends on vpts_pkg.
interface vpts_vtx_if;
  import vpts_pkg::*;
  logic valid;
  logic ready;
  vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vpts_scr_if;
  import vpts_pkg::*;
  logic valid;
  logic ready;
  scr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vpts_cfg_if;
  import vpts_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vertex_perspective_to_screen.sv
// Vertex perspective-to-screen: projection, perspective divide, viewport map.
// Eleven register stages; one vertex per cycle sustained while the screen output is ready.
// The divide is a restoring divider of 24 quotient bits, 4 bits per stage over 6 stages.
// Each stage stalls only when it and every stage after it are full.
// Reset empties the pipeline and loads the default projection (640x480 screen).
// Depends on vpts_pkg and vpts_if.
module vertex_perspective_to_screen #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpts_cfg_if.sink    cfg_i,
  vpts_vtx_if.sink    vtx_i,
  vpts_scr_if.source  scr_o
);
  import vpts_pkg::*;

  localparam int PW  = 24 + COORD_BITS;              // coefficient times coordinate
  localparam int NW  = ((PW > 57) ? PW : 57) + 1;    // depth numerator
  localparam int DW  = (COORD_BITS > 17) ? COORD_BITS : 17;
  localparam int HW  = NW - 24;
  localparam int NS  = 11;
  localparam int VW  = 26;
  localparam int TW  = VW + 14;
  localparam logic signed [17:0]   UNIT = 18'(UNIT_DIV);
  localparam logic signed [VW-1:0] ONE  = VW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] BIAS = (TW'(1) << (FRAC_BITS + 1)) - TW'(1);

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] d;
    logic [23:0]   lo;
    logic [23:0]   q;
    logic          neg;
    logic          ovf;
  } lane_t;

  function automatic lane_t div_step4(lane_t l);
    lane_t         r;
    logic [DW:0]   t;
    r = l;
    for (int i = 0; i < 4; i++) begin
      t    = {r.rem, r.lo[23]};
      r.lo = {r.lo[22:0], 1'b0};
      if (t >= {1'b0, r.d}) begin
        r.rem = DW'(t - {1'b0, r.d});
        r.q   = {r.q[22:0], 1'b1};
      end else begin
        r.rem = t[DW-1:0];
        r.q   = {r.q[22:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic lane_t div_init(logic signed [NW-1:0] n, logic [DW-1:0] d,
                                     logic neg);
    lane_t         r;
    logic [NW-1:0] mag;
    mag   = n[NW-1] ? NW'(-n) : NW'(n);
    r.d   = d;
    r.ovf = (mag[NW-1:24] >= HW'(d));
    r.rem = mag[DW+23:24];
    r.lo  = mag[23:0];
    r.q   = '0;
    r.neg = n[NW-1] ^ neg;
    return r;
  endfunction

  function automatic logic signed [23:0] div_sat(lane_t l);
    logic signed [23:0] v;
    if (l.ovf || (l.q > (l.neg ? 24'h800000 : 24'h7FFFFF))) begin
      v = l.neg ? Q_MIN : Q_MAX;
    end else begin
      v = l.neg ? -$signed(l.q) : $signed(l.q);
    end
    return v;
  endfunction

  function automatic logic signed [TW-1:0] scr_mul(logic signed [23:0] v,
                                                   logic [12:0] size);
    logic signed [VW-1:0] diff;
    diff = ONE - VW'(v);
    return diff * $signed({1'b0, size});
  endfunction

  function automatic logic signed [15:0] scr_fin(logic signed [TW-1:0] t);
    logic signed [TW-1:0] s;
    s = (t[TW-1] ? t + BIAS : t) >>> (FRAC_BITS + 1);
    if (s > TW'(32767)) begin
      return 16'sh7FFF;
    end else if (s < -TW'(32768)) begin
      return -16'sh8000;
    end
    return s[15:0];
  endfunction

  // configuration registers
  logic signed [23:0] scale_x_q, scale_y_q, depth_a_q, depth_b_q;
  logic [12:0]        screen_w_q, screen_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= 24'sd65536;
      scale_y_q  <= 24'sd65536;
      depth_a_q  <= -24'sd65536;
      depth_b_q  <= '0;
      screen_w_q <= 13'd640;
      screen_h_q <= 13'd480;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.idx)
        REG_SCALE_X:  scale_x_q  <= cfg_i.data.wdata;
        REG_SCALE_Y:  scale_y_q  <= cfg_i.data.wdata;
        REG_DEPTH_A:  depth_a_q  <= cfg_i.data.wdata;
        REG_DEPTH_B:  depth_b_q  <= cfg_i.data.wdata;
        REG_SCREEN_W: screen_w_q <= cfg_i.data.wdata[12:0];
        REG_SCREEN_H: screen_h_q <= cfg_i.data.wdata[12:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = scr_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? vtx_i.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign vtx_i.ready = en[0];
  assign scr_o.valid = v_q[NS-1];

  // stage 1: products
  logic signed [COORD_BITS-1:0] xc, yc, zc;
  logic signed [PW-1:0]         px1_q, py1_q, pz1_q;
  logic signed [39:0]           pw1_q;
  logic signed [COORD_BITS-1:0] z1_q;

  assign xc = vtx_i.data.x_pos[COORD_BITS-1:0];
  assign yc = vtx_i.data.y_pos[COORD_BITS-1:0];
  assign zc = vtx_i.data.z_pos[COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px1_q <= scale_x_q * xc;
      py1_q <= scale_y_q * yc;
      pz1_q <= depth_a_q * zc;
      pw1_q <= depth_b_q * vtx_i.data.w_pos;
      z1_q  <= zc;
    end
  end

  // stage 2: scale w term to coordinate units
  logic signed [PW-1:0]         px2_q, py2_q, pz2_q;
  logic signed [39:0]           pw2_q;
  logic signed [56:0]           pwk2_q;
  logic signed [COORD_BITS-1:0] z2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      pz2_q  <= pz1_q;
      pw2_q  <= pw1_q;
      pwk2_q <= pw1_q * UNIT;
      z2_q   <= z1_q;
    end
  end

  // stage 3: numerators, divisors and signs; stages 4-9: divider
  lane_t ln_q [7][3];
  logic  wz_q [7];
  lane_t ln0_d [3];
  logic  wz0_d;

  always_comb begin
    logic [DW-1:0]       zmag;
    logic signed [NW-1:0] nz;
    zmag  = z2_q[COORD_BITS-1] ? DW'(-{z2_q[COORD_BITS-1], z2_q})
                               : DW'(z2_q);
    nz    = NW'(pz2_q) + NW'(pwk2_q);
    wz0_d = (z2_q == '0);
    if (wz0_d) begin
      ln0_d[0] = div_init(NW'(px2_q), DW'(UNIT_DIV), 1'b0);
      ln0_d[1] = div_init(NW'(py2_q), DW'(UNIT_DIV), 1'b0);
      ln0_d[2] = div_init(NW'(pw2_q), DW'(1), 1'b0);
    end else begin
      // clip w is -z: negate the quotient
      ln0_d[0] = div_init(NW'(px2_q), zmag, !z2_q[COORD_BITS-1]);
      ln0_d[1] = div_init(NW'(py2_q), zmag, !z2_q[COORD_BITS-1]);
      ln0_d[2] = div_init(nz, zmag, !z2_q[COORD_BITS-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ln_q[0] <= ln0_d;
      wz_q[0] <= wz0_d;
    end
    for (int k = 0; k < 6; k++) begin
      if (en[k+3]) begin
        for (int j = 0; j < 3; j++) begin
          ln_q[k+1][j] <= div_step4(ln_q[k][j]);
        end
        wz_q[k+1] <= wz_q[k];
      end
    end
  end

  // stage 10: saturate quotients, viewport products
  logic signed [TW-1:0] tx_q, ty_q;
  logic signed [23:0]   ndc_q;
  logic                 wz10_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      tx_q   <= scr_mul(div_sat(ln_q[6][0]), screen_w_q);
      ty_q   <= scr_mul(div_sat(ln_q[6][1]), screen_h_q);
      ndc_q  <= div_sat(ln_q[6][2]);
      wz10_q <= wz_q[6];
    end
  end

  // stage 11: halve, truncate and saturate into the output register
  scr_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      out_q.screen_x   <= scr_fin(tx_q);
      out_q.screen_y   <= scr_fin(ty_q);
      out_q.ndc_depth  <= ndc_q;
      out_q.w_was_zero <= wz10_q;
    end
  end

  assign scr_o.data = out_q;

  // assertions
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vtx_i.ready |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (ln_q[0][0].d != '0) && (ln_q[0][2].d != '0))
    else $error("divider loaded with a zero divisor");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[8] && !ln_q[6][2].ovf) |-> (ln_q[6][2].rem < ln_q[6][2].d))
    else $error("divider remainder out of range");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scr_o.ready && !v_q[9]) |=> !scr_o.valid)
    else $error("output valid without a feeding stage");

endmodule

FILE: verif/vertex_perspective_to_screen_tb.sv
// Self-checking bench for vertex_perspective_to_screen: projection, divide, viewport map.
// Holds its own projection predictor and drives the vertex, config and screen channels.
// Depends on vpts_pkg, vpts_if and the RTL top level.
module vertex_perspective_to_screen_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vpts_pkg::*;

  localparam int     FRAC     = 16;
  localparam longint ONE_Q    = longint'(1) << FRAC;
  localparam longint QHI      = 8388607;
  localparam longint QLO      = -8388608;
  localparam int     N_PHASES = 8;
  localparam int     PHASE_N  = 235;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  vpts_cfg_if cfg ();
  vpts_vtx_if vtx ();
  vpts_scr_if scr ();

  vertex_perspective_to_screen uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg.sink),
    .vtx_i (vtx.sink),
    .scr_o (scr.source)
  );

  // projection registers as the block should hold them
  logic signed [23:0] k_sx, k_sy, k_da, k_db;
  logic        [12:0] k_wd, k_ht;

  vtx_t   vtx_pending[$];
  scr_t   scr_expected[$];
  int     n_queued  = 0;
  int     n_checked = 0;
  int     n_errors  = 0;
  bit     calm      = 1'b0;
  bit     hold_out  = 1'b0;
  int     phase_no  = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint viewport(longint v, longint size);
    return clamp(((ONE_Q - v) * size) / (2 * ONE_Q), -32768, 32767);
  endfunction

  function automatic scr_t project(vtx_t v);
    longint x, y, z, w, sx, sy, da, db, px, py, pz;
    scr_t r;
    x  = longint'($signed(v.x_pos));
    y  = longint'($signed(v.y_pos));
    z  = longint'($signed(v.z_pos));
    w  = longint'($signed(v.w_pos));
    sx = longint'(k_sx);
    sy = longint'(k_sy);
    da = longint'(k_da);
    db = longint'(k_db);
    if (z != 0) begin
      px = -(sx * x) / z;
      py = -(sy * y) / z;
      pz = -(da * z + db * w * longint'(UNIT_DIV)) / z;
    end else begin
      px = (sx * x) / longint'(UNIT_DIV);
      py = (sy * y) / longint'(UNIT_DIV);
      pz = db * w;
    end
    px = clamp(px, QLO, QHI);
    py = clamp(py, QLO, QHI);
    pz = clamp(pz, QLO, QHI);
    r.screen_x   = 16'(viewport(px, longint'(k_wd)));
    r.screen_y   = 16'(viewport(py, longint'(k_ht)));
    r.ndc_depth  = 24'(pz);
    r.w_was_zero = (z == 0);
    return r;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // vertex driver
  int tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    if (!rst_ni) begin
      vtx.valid <= 1'b0;
      vtx.data  <= '0;
      tx_gap    = 0;
    end else begin
      nv = vtx.valid;
      if (vtx.valid && vtx.ready) begin
        scr_expected = {scr_expected, project(vtx.data)};
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (vtx_pending.size() > 0) begin
          vtx.data <= vtx_pending.pop_front();
          nv = 1'b1;
          tx_gap = draw_gap();
        end
      end
      vtx.valid <= nv;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d expected %0d", what, n_checked, got, want);
    n_errors++;
  endtask

  // screen monitor
  int rx_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    scr_t want;
    if (!rst_ni) begin
      scr.ready <= 1'b0;
      rx_stall  = 0;
    end else begin
      if (scr.valid && scr.ready) begin
        if (scr_expected.size() == 0) begin
          $display("unexpected result transaction");
          n_errors++;
        end else begin
          want = scr_expected.pop_front();
          if (scr.data.screen_x !== want.screen_x)
            report("screen_x", scr.data.screen_x, want.screen_x);
          if (scr.data.screen_y !== want.screen_y)
            report("screen_y", scr.data.screen_y, want.screen_y);
          if (scr.data.ndc_depth !== want.ndc_depth)
            report("ndc_depth", scr.data.ndc_depth, want.ndc_depth);
          if (scr.data.w_was_zero !== want.w_was_zero)
            report("w_was_zero", scr.data.w_was_zero, want.w_was_zero);
        end
        n_checked++;
        rx_stall = draw_gap();
      end
      if (hold_out) begin
        scr.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        scr.ready <= 1'b0;
      end else begin
        scr.ready <= 1'b1;
      end
    end
  end

  // long back-pressure so the pipeline fills and stalls the vertex input
  initial begin
    wait (phase_no == 3);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #5ms;
    $display("FAIL vertex_perspective_to_screen");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data  <= {reg_idx_e'(idx), val};
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_SCALE_X:  k_sx = val;
      REG_SCALE_Y:  k_sy = val;
      REG_DEPTH_A:  k_da = val;
      REG_DEPTH_B:  k_db = val;
      REG_SCREEN_W: k_wd = val[12:0];
      REG_SCREEN_H: k_ht = val[12:0];
      default: ;
    endcase
  endtask

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, int w);
    vtx_t v;
    v.x_pos = x;
    v.y_pos = y;
    v.z_pos = z;
    v.w_pos = 16'(w);
    vtx_pending = {vtx_pending, v};
    n_queued++;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (n_checked != n_queued);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord(bit depth);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return depth ? -32'($urandom_range(1000, 3_000_000))
                            : 32'($signed($urandom_range(0, 800_000)) - 400_000);
    endcase
  endfunction

  function automatic logic [23:0] q_value(bit depth);
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom());
      default: return depth ? -24'($urandom_range(60000, 80000))
                            : 24'($urandom_range(30000, 250000));
    endcase
  endfunction

  function automatic logic [23:0] size_value();
    case ($urandom_range(0, 6))
      0:       return 24'd1;
      1:       return 24'd4096;
      2:       return 24'd0;
      3:       return 24'd8191;
      default: return 24'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    logic [31:0] zc;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    k_sx = 24'sd65536;
    k_sy = 24'sd65536;
    k_da = -24'sd65536;
    k_db = '0;
    k_wd = 13'd640;
    k_ht = 13'd480;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default projection, extremes, zero clip w, near-zero divisors
    calm = 1'b1;
    send(0, 0, 0, 0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'h7FFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h8000);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 16'h8000);
    send(100000, -100000, -100000, 1);
    send(-50000, 50000, -200000, -1);
    send(1, -1, -1, 0);
    send(12345, 67890, -500000, 1);
    send(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    send(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    drain();

    // sizes 0 and beyond 4096, extreme depth terms, stray register indexes
    write_reg(REG_SCREEN_W, 24'd0);
    write_reg(REG_SCREEN_H, 24'd8191);
    write_reg(REG_DEPTH_B, 24'h7FFFFF);
    write_reg(REG_DEPTH_A, 24'h800000);
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    send(300000, -300000, -100000, 16'h7FFF);
    send(-300000, 300000, 0, 16'h8000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 16'h7FFF);
    send(5, 5, 32'hFFFF_FFFF, 16'h8000);
    drain();

    for (int p = 1; p <= N_PHASES; p++) begin
      phase_no = p;
      calm = (p % 3 == 2);
      if (p == 1) begin
        write_reg(REG_SCALE_X, 24'h7FFFFF);
        write_reg(REG_SCALE_Y, 24'h800000);
        write_reg(REG_DEPTH_A, 24'h7FFFFF);
        write_reg(REG_DEPTH_B, 24'h800000);
        write_reg(REG_SCREEN_W, 24'd4096);
        write_reg(REG_SCREEN_H, 24'd1);
      end else if (p == 2) begin
        write_reg(REG_SCALE_X, 24'd78000);
        write_reg(REG_SCALE_Y, 24'd104000);
        write_reg(REG_DEPTH_A, -24'd65800);
        write_reg(REG_DEPTH_B, -24'd13100);
        write_reg(REG_SCREEN_W, 24'd1);
        write_reg(REG_SCREEN_H, 24'd4096);
      end else begin
        write_reg(REG_SCALE_X, q_value(1'b0));
        write_reg(REG_SCALE_Y, q_value(1'b0));
        write_reg(REG_DEPTH_A, q_value(1'b1));
        write_reg(REG_DEPTH_B, q_value(1'b1));
        write_reg(REG_SCREEN_W, size_value());
        write_reg(REG_SCREEN_H, size_value());
      end
      for (int i = 0; i < PHASE_N; i++) begin
        zc = ($urandom_range(0, 9) == 0) ? 32'd0 : coord(1'b1);
        send(coord(1'b0), coord(1'b0), zc, $urandom());
      end
      drain();
    end

    if (n_errors == 0)
      $display("PASS vertex_perspective_to_screen");
    else
      $display("FAIL vertex_perspective_to_screen");
    $finish;
  end

endmodule
